@@ hdl/psi_pkg.sv @@
`timescale 1ns / 1ps
package psi_pkg;

   localparam int VEC_FRAC_BITS = 14;
   localparam int PROB_BITS     = 16;
   localparam int NORM_GUARD    = 14;

   localparam int VEC_W   = 16;
   // The sum or difference of two full-scale components needs one bit more than a field.
   localparam int MAG_W   = 17;
   localparam int DOT_W   = 2 * VEC_W + 2;
   localparam int PROD_W  = DOT_W + VEC_W;
   localparam int NORM_W  = 2 * MAG_W + 2;
   localparam int RAD_W   = NORM_W + 2 * NORM_GUARD;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int QUO_W   = VEC_FRAC_BITS + 2;
   localparam int REM_W   = ROOT_W + 1 + QUO_W;
   localparam int SQRT_STAGES = RAD_W / 2;
   localparam int CSR_ADDR_W  = 4;

   localparam int RND_SHIFT = 2 * VEC_FRAC_BITS - 1;
   localparam longint SMALL_NORM2 =
      ((longint'(1) << (2 * VEC_FRAC_BITS)) + 64'd999999) / 64'd1000000;

   localparam logic signed [23:0] VEC_ONE       = 24'sd1 <<< VEC_FRAC_BITS;
   localparam logic signed [23:0] VEC_MINUS_ONE = -VEC_ONE;

   localparam logic [1:0] MODE_ISO  = 2'd0;
   localparam logic [1:0] MODE_BACK = 2'd1;
   localparam logic [1:0] MODE_FWD  = 2'd2;

   localparam logic [1:0] OUT_ABSORBED = 2'd0;
   localparam logic [1:0] OUT_BACK     = 2'd1;
   localparam logic [1:0] OUT_FORWARD  = 2'd2;
   localparam logic [1:0] OUT_NONE     = 2'd3;

   localparam logic [1:0] PROC_ABSORPTION   = 2'd0;
   localparam logic [1:0] PROC_SPECULAR     = 2'd1;
   localparam logic [1:0] PROC_LAMBERT      = 2'd2;
   localparam logic [1:0] PROC_TRANSMISSION = 2'd3;

   typedef struct packed {
      logic [PROB_BITS-1:0] random_fraction;
      logic signed [VEC_W-1:0] dir_x;
      logic signed [VEC_W-1:0] dir_y;
      logic signed [VEC_W-1:0] dir_z;
      logic signed [VEC_W-1:0] normal_x;
      logic signed [VEC_W-1:0] normal_y;
      logic signed [VEC_W-1:0] normal_z;
      logic signed [VEC_W-1:0] random_dir_x;
      logic signed [VEC_W-1:0] random_dir_y;
      logic signed [VEC_W-1:0] random_dir_z;
   } psi_req_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] new_dir_x;
      logic signed [VEC_W-1:0] new_dir_y;
      logic signed [VEC_W-1:0] new_dir_z;
      logic [1:0] outcome;
      logic [1:0] process;
      logic       retry;
   } psi_rsp_type;

   typedef struct packed {
      logic [PROB_BITS-1:0] loss_probability;
      logic [PROB_BITS-1:0] specular_probability;
      logic [PROB_BITS-1:0] scatter_probability;
      logic [1:0]           scatter_mode;
   } psi_cfg_type;

   // Everything an item carries past the front end besides the radicand.
   typedef struct packed {
      logic [2:0][VEC_W-1:0] alt;
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  lamb;
      logic [1:0]            outcome;
      logic [1:0]            process;
      logic                  retry;
   } psi_side_type;

   function automatic logic [VEC_W-1:0] sat_vec(input logic signed [23:0] v);
      logic signed [23:0] c;
      c = v;
      if (v > VEC_ONE) begin
         c = VEC_ONE;
      end else if (v < VEC_MINUS_ONE) begin
         c = VEC_MINUS_ONE;
      end
      return c[VEC_W-1:0];
   endfunction

endpackage

@@ hdl/psi_csr.sv @@
`timescale 1ns / 1ps
module psi_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [psi_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output psi_pkg::psi_cfg_type            cfg
);

   localparam logic [1:0] REG_LOSS     = 2'd0;
   localparam logic [1:0] REG_SPECULAR = 2'd1;
   localparam logic [1:0] REG_SCATTER  = 2'd2;
   localparam logic [1:0] REG_MODE     = 2'd3;

   psi_pkg::psi_cfg_type cfg_ff;
   logic [1:0]           index;

   assign index      = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (index)
            REG_LOSS:     cfg_ff.loss_probability     <= csr_pwdata[psi_pkg::PROB_BITS-1:0];
            REG_SPECULAR: cfg_ff.specular_probability <= csr_pwdata[psi_pkg::PROB_BITS-1:0];
            REG_SCATTER:  cfg_ff.scatter_probability  <= csr_pwdata[psi_pkg::PROB_BITS-1:0];
            REG_MODE:     cfg_ff.scatter_mode         <= csr_pwdata[1:0];
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_LOSS:     csr_prdata = 32'(cfg_ff.loss_probability);
         REG_SPECULAR: csr_prdata = 32'(cfg_ff.specular_probability);
         REG_SCATTER:  csr_prdata = 32'(cfg_ff.scatter_probability);
         REG_MODE:     csr_prdata = 32'(cfg_ff.scatter_mode);
         default:      csr_prdata = '0;
      endcase
   end

endmodule

@@ hdl/psi_front.sv @@
`timescale 1ns / 1ps
module psi_front (
   input  logic                          clock,
   input  logic                          reset,
   input  psi_pkg::psi_cfg_type          cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  psi_pkg::psi_req_type          in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [psi_pkg::RAD_W-1:0]     out_radicand,
   output psi_pkg::psi_side_type         out_side
);

   localparam int VW = psi_pkg::VEC_W;
   localparam int DW = psi_pkg::DOT_W;
   localparam int PW = psi_pkg::PROD_W;
   localparam int NW = psi_pkg::NORM_W;
   localparam int MW = psi_pkg::MAG_W;

   typedef enum logic [2:0] {
      CAT_ABSORB, CAT_SPECULAR, CAT_ISO, CAT_LAMBERT, CAT_NONE
   } cat_type;

   logic [3:0] valid_ff;
   logic [3:0] en;

   assign en[3] = !valid_ff[3] || out_ready;
   assign en[2] = !valid_ff[2] || en[3];
   assign en[1] = !valid_ff[1] || en[2];
   assign en[0] = !valid_ff[0] || en[1];

   assign in_ready  = en[0];
   assign out_valid = valid_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         if (en[1]) valid_ff[1] <= valid_ff[0];
         if (en[2]) valid_ff[2] <= valid_ff[1];
         if (en[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   // Stage 1: window decision, difference or sum vector and the dot product terms.
   logic signed [VW-1:0] k_cur[3], n_cur[3], r_cur[3];
   logic [PW/2-8:0]      unused_guard;
   logic [psi_pkg::PROB_BITS:0]   lim2;
   logic [psi_pkg::PROB_BITS+1:0] lim3;
   cat_type              cat1_in, cat1_ff;
   logic                 fwd1_in, fwd1_ff;
   logic signed [VW:0]   v_sum;
   logic signed [VW-1:0] k1_ff[3], n1_ff[3], r1_ff[3];
   logic signed [2*VW-1:0] kn1_in[3], kn1_ff[3], rn1_in[3], rn1_ff[3];
   logic [MW-1:0]        mag1_in[3], mag1_ff[3];
   logic [2:0]           neg1_in, neg1_ff;

   assign unused_guard = '0;

   assign k_cur[0] = in_data.dir_x;
   assign k_cur[1] = in_data.dir_y;
   assign k_cur[2] = in_data.dir_z;
   assign n_cur[0] = in_data.normal_x;
   assign n_cur[1] = in_data.normal_y;
   assign n_cur[2] = in_data.normal_z;
   assign r_cur[0] = in_data.random_dir_x;
   assign r_cur[1] = in_data.random_dir_y;
   assign r_cur[2] = in_data.random_dir_z;

   assign lim2 = {1'b0, cfg.loss_probability} + {1'b0, cfg.specular_probability};
   assign lim3 = {1'b0, lim2} + {2'b0, cfg.scatter_probability};
   assign fwd1_in = (cfg.scatter_mode == psi_pkg::MODE_FWD);

   always_comb begin
      cat1_in = CAT_NONE;
      if (in_data.random_fraction < cfg.loss_probability) begin
         cat1_in = CAT_ABSORB;
      end else if ({1'b0, in_data.random_fraction} < lim2) begin
         cat1_in = CAT_SPECULAR;
      end else if ({2'b0, in_data.random_fraction} < lim3) begin
         unique case (cfg.scatter_mode)
            psi_pkg::MODE_ISO:  cat1_in = CAT_ISO;
            psi_pkg::MODE_BACK: cat1_in = CAT_LAMBERT;
            psi_pkg::MODE_FWD:  cat1_in = CAT_LAMBERT;
            default:            cat1_in = CAT_NONE;
         endcase
      end
   end

   always_comb begin
      v_sum = '0;
      for (int i = 0; i < 3; i++) begin
         kn1_in[i] = (2*VW)'(k_cur[i]) * (2*VW)'(n_cur[i]);
         rn1_in[i] = (2*VW)'(r_cur[i]) * (2*VW)'(n_cur[i]);
         v_sum = fwd1_in ? ((VW+1)'(r_cur[i]) + (VW+1)'(n_cur[i]))
                         : ((VW+1)'(r_cur[i]) - (VW+1)'(n_cur[i]));
         neg1_in[i] = v_sum[VW];
         mag1_in[i] = v_sum[VW] ? MW'(-v_sum) : MW'(v_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cat1_ff <= cat1_in;
         fwd1_ff <= fwd1_in;
         neg1_ff <= neg1_in;
         for (int i = 0; i < 3; i++) begin
            k1_ff[i]   <= k_cur[i];
            n1_ff[i]   <= n_cur[i];
            r1_ff[i]   <= r_cur[i];
            kn1_ff[i]  <= kn1_in[i];
            rn1_ff[i]  <= rn1_in[i];
            mag1_ff[i] <= mag1_in[i];
         end
      end
   end

   // Stage 2: dot products and squared magnitudes.
   logic signed [DW-1:0] d2_in, d2_ff, rdot;
   logic                 rneg2_ff;
   logic [2*MW-1:0]      sq2_in[3], sq2_ff[3];
   cat_type              cat2_ff;
   logic                 fwd2_ff;
   logic [2:0]           neg2_ff;
   logic signed [VW-1:0] k2_ff[3], n2_ff[3], r2_ff[3];
   logic [MW-1:0]        mag2_ff[3];

   always_comb begin
      d2_in = DW'(kn1_ff[0]) + DW'(kn1_ff[1]) + DW'(kn1_ff[2]);
      rdot  = DW'(rn1_ff[0]) + DW'(rn1_ff[1]) + DW'(rn1_ff[2]);
      for (int i = 0; i < 3; i++) begin
         sq2_in[i] = (2*MW)'(mag1_ff[i]) * (2*MW)'(mag1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         d2_ff    <= d2_in;
         rneg2_ff <= rdot[DW-1];
         cat2_ff  <= cat1_ff;
         fwd2_ff  <= fwd1_ff;
         neg2_ff  <= neg1_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i]  <= sq2_in[i];
            k2_ff[i]   <= k1_ff[i];
            n2_ff[i]   <= n1_ff[i];
            r2_ff[i]   <= r1_ff[i];
            mag2_ff[i] <= mag1_ff[i];
         end
      end
   end

   // Stage 3: (N.K)N for the mirror term and the squared norm.
   logic signed [PW-1:0] dn3_in[3], dn3_ff[3];
   logic [NW-1:0]        norm3_in, norm3_ff;
   cat_type              cat3_ff;
   logic                 fwd3_ff, rneg3_ff;
   logic [2:0]           neg3_ff;
   logic signed [VW-1:0] k3_ff[3], r3_ff[3];
   logic [MW-1:0]        mag3_ff[3];

   always_comb begin
      norm3_in = NW'(sq2_ff[0]) + NW'(sq2_ff[1]) + NW'(sq2_ff[2]);
      for (int i = 0; i < 3; i++) begin
         dn3_in[i] = PW'(d2_ff) * PW'(n2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         norm3_ff <= norm3_in;
         cat3_ff  <= cat2_ff;
         fwd3_ff  <= fwd2_ff;
         rneg3_ff <= rneg2_ff;
         neg3_ff  <= neg2_ff;
         for (int i = 0; i < 3; i++) begin
            dn3_ff[i]  <= dn3_in[i];
            k3_ff[i]   <= k2_ff[i];
            r3_ff[i]   <= r2_ff[i];
            mag3_ff[i] <= mag2_ff[i];
         end
      end
   end

   // Stage 4: mirror rounding, result codes and the small norm test.
   psi_pkg::psi_side_type      side4_in, side4_ff;
   logic [psi_pkg::RAD_W-1:0]  rad4_ff;
   logic                       norm_short;

   assign norm_short = (norm3_ff < NW'(psi_pkg::SMALL_NORM2));

   always_comb begin
      logic [PW-1:0]      dn_abs;
      logic [PW-1:0]      rnd_mag;
      logic signed [23:0] m24;
      logic signed [23:0] spec;
      side4_in = '0;
      side4_in.neg = neg3_ff;
      for (int i = 0; i < 3; i++) begin
         side4_in.mag[i] = mag3_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         dn_abs  = dn3_ff[i][PW-1] ? PW'(-dn3_ff[i]) : PW'(dn3_ff[i]);
         rnd_mag = (dn_abs + (PW'(1) << (psi_pkg::RND_SHIFT - 1))) >> psi_pkg::RND_SHIFT;
         m24     = $signed(24'(rnd_mag));
         spec    = dn3_ff[i][PW-1] ? (24'(k3_ff[i]) + m24) : (24'(k3_ff[i]) - m24);
         case (cat3_ff)
            CAT_SPECULAR: side4_in.alt[i] = psi_pkg::sat_vec(spec);
            CAT_ISO:      side4_in.alt[i] = psi_pkg::sat_vec(24'(r3_ff[i]));
            CAT_LAMBERT:  side4_in.alt[i] = '0;
            default:      side4_in.alt[i] = psi_pkg::sat_vec(24'(k3_ff[i]));
         endcase
      end
      unique case (cat3_ff)
         CAT_ABSORB: begin
            side4_in.outcome = psi_pkg::OUT_ABSORBED;
            side4_in.process = psi_pkg::PROC_ABSORPTION;
         end
         CAT_SPECULAR: begin
            side4_in.outcome = psi_pkg::OUT_BACK;
            side4_in.process = psi_pkg::PROC_SPECULAR;
         end
         CAT_ISO: begin
            side4_in.outcome = rneg3_ff ? psi_pkg::OUT_BACK : psi_pkg::OUT_FORWARD;
            side4_in.process = rneg3_ff ? psi_pkg::PROC_LAMBERT : psi_pkg::PROC_TRANSMISSION;
         end
         CAT_LAMBERT: begin
            side4_in.outcome = fwd3_ff ? psi_pkg::OUT_FORWARD : psi_pkg::OUT_BACK;
            side4_in.process = fwd3_ff ? psi_pkg::PROC_TRANSMISSION : psi_pkg::PROC_LAMBERT;
            side4_in.retry   = norm_short;
            side4_in.lamb    = !norm_short;
         end
         default: begin
            side4_in.outcome = psi_pkg::OUT_NONE;
            side4_in.process = psi_pkg::PROC_TRANSMISSION;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         side4_ff <= side4_in;
         rad4_ff  <= {norm3_ff, {(2*psi_pkg::NORM_GUARD){1'b0}}} | psi_pkg::RAD_W'(unused_guard);
      end
   end

   assign out_side     = side4_ff;
   assign out_radicand = rad4_ff;

endmodule

@@ hdl/psi_sqrt.sv @@
`timescale 1ns / 1ps
module psi_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [psi_pkg::RAD_W-1:0]     in_radicand,
   input  psi_pkg::psi_side_type         in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [psi_pkg::ROOT_W-1:0]    out_root,
   output psi_pkg::psi_side_type         out_side
);

   localparam int STAGES = psi_pkg::SQRT_STAGES;
   localparam int W      = psi_pkg::RAD_W + 1;

   logic [STAGES-1:0]     valid_ff, en;
   logic [W-1:0]          x_ff[STAGES], r_ff[STAGES];
   logic [W-1:0]          x_cur[STAGES], r_cur[STAGES];
   logic [W-1:0]          x_in[STAGES], r_in[STAGES];
   psi_pkg::psi_side_type side_ff[STAGES], side_in[STAGES];

   assign en[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
   for (genvar j = 0; j < STAGES - 1; j++) begin : g_en
      assign en[j] = !valid_ff[j] || en[j+1];
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = r_ff[STAGES-1][psi_pkg::ROOT_W-1:0];
   assign out_side  = side_ff[STAGES-1];

   // One root bit per stage; the trial bit of stage j is 4 to the power STAGES-1-j.
   always_comb begin
      logic [W-1:0] one_bit;
      logic [W-1:0] trial;
      x_cur[0]   = W'(in_radicand);
      r_cur[0]   = '0;
      side_in[0] = in_side;
      for (int j = 1; j < STAGES; j++) begin
         x_cur[j]   = x_ff[j-1];
         r_cur[j]   = r_ff[j-1];
         side_in[j] = side_ff[j-1];
      end
      for (int j = 0; j < STAGES; j++) begin
         one_bit = W'(1) << (2 * (STAGES - 1 - j));
         trial   = r_cur[j] + one_bit;
         if (x_cur[j] >= trial) begin
            x_in[j] = x_cur[j] - trial;
            r_in[j] = (r_cur[j] >> 1) + one_bit;
         end else begin
            x_in[j] = x_cur[j];
            r_in[j] = r_cur[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         for (int j = 1; j < STAGES; j++) begin
            if (en[j]) valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < STAGES; j++) begin
         if (en[j]) begin
            x_ff[j]    <= x_in[j];
            r_ff[j]    <= r_in[j];
            side_ff[j] <= side_in[j];
         end
      end
   end

endmodule

@@ hdl/psi_div.sv @@
`timescale 1ns / 1ps
module psi_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [psi_pkg::ROOT_W-1:0]          in_root,
   input  psi_pkg::psi_side_type               in_side,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [2:0][psi_pkg::QUO_W-1:0]      out_quo,
   output psi_pkg::psi_side_type               out_side
);

   localparam int STAGES = psi_pkg::QUO_W;
   localparam int RW     = psi_pkg::REM_W;
   localparam int DEN_W  = psi_pkg::ROOT_W + 1;
   localparam int QW     = psi_pkg::QUO_W;
   localparam int NUM_SH = psi_pkg::VEC_FRAC_BITS + psi_pkg::NORM_GUARD + 1;

   logic [STAGES-1:0]     valid_ff, en;
   logic [RW-1:0]         rem_ff[STAGES][3], rem_cur[STAGES][3], rem_in[STAGES][3];
   logic [QW-1:0]         q_ff[STAGES][3], q_cur[STAGES][3], q_in[STAGES][3];
   logic [DEN_W-1:0]      den_ff[STAGES], den_in[STAGES];
   psi_pkg::psi_side_type side_ff[STAGES], side_in[STAGES];

   assign en[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
   for (genvar j = 0; j < STAGES - 1; j++) begin : g_en
      assign en[j] = !valid_ff[j] || en[j+1];
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_quo[i] = q_ff[STAGES-1][i];
      end
   end

   // Rounded quotient: (2|v|2^28 + s) / 2s, one quotient bit per stage, MSB first.
   always_comb begin
      logic [RW-1:0] shifted;
      den_in[0]  = {in_root, 1'b0};
      side_in[0] = in_side;
      for (int i = 0; i < 3; i++) begin
         rem_cur[0][i] = (RW'(in_side.mag[i]) << NUM_SH) + RW'(in_root);
         q_cur[0][i]   = '0;
      end
      for (int j = 1; j < STAGES; j++) begin
         den_in[j]  = den_ff[j-1];
         side_in[j] = side_ff[j-1];
         for (int i = 0; i < 3; i++) begin
            rem_cur[j][i] = rem_ff[j-1][i];
            q_cur[j][i]   = q_ff[j-1][i];
         end
      end
      for (int j = 0; j < STAGES; j++) begin
         for (int i = 0; i < 3; i++) begin
            shifted = RW'(den_in[j]) << (STAGES - 1 - j);
            if (rem_cur[j][i] >= shifted) begin
               rem_in[j][i] = rem_cur[j][i] - shifted;
               q_in[j][i]   = q_cur[j][i] | (QW'(1) << (STAGES - 1 - j));
            end else begin
               rem_in[j][i] = rem_cur[j][i];
               q_in[j][i]   = q_cur[j][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         for (int j = 1; j < STAGES; j++) begin
            if (en[j]) valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < STAGES; j++) begin
         if (en[j]) begin
            den_ff[j]  <= den_in[j];
            side_ff[j] <= side_in[j];
            for (int i = 0; i < 3; i++) begin
               rem_ff[j][i] <= rem_in[j][i];
               q_ff[j][i]   <= q_in[j][i];
            end
         end
      end
   end

endmodule

@@ hdl/photon_surface_interaction.sv @@
`timescale 1ns / 1ps
// Decides the fate of one photon at a surface per beat: absorption, mirror
// reflection or scattering (isotropic or Lambertian, chosen by scatter_mode),
// else the photon is handed on for Fresnel handling. A beat may be taken in
// every cycle while the result side is ready; each result passes through 4 front
// stages (window compare, dot products, mirror term, rounding), 32 square root
// stages that settle one root bit each, 16 divider stages that settle one
// quotient bit each for all three components, and the output register. Stalls
// back up stage by stage, so empty stages keep filling while a result waits.
// A Lambertian direction too short to normalise comes back as a zero vector
// with retry set; the request should be sent again with a fresh random
// direction. Registers are to be written over the CSR port only while the
// block holds no beats; the block itself does not enforce this.
module photon_surface_interaction (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  psi_pkg::psi_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output psi_pkg::psi_rsp_type           rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [psi_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   psi_pkg::psi_cfg_type  cfg;
   logic                  fr_valid, fr_ready, sq_valid, sq_ready, dv_valid, dv_ready;
   logic [psi_pkg::RAD_W-1:0]          fr_radicand;
   logic [psi_pkg::ROOT_W-1:0]         sq_root;
   logic [2:0][psi_pkg::QUO_W-1:0]     dv_quo;
   psi_pkg::psi_side_type fr_side, sq_side, dv_side;
   psi_pkg::psi_rsp_type  rsp_in, rsp_ff;
   logic                  rsp_valid_ff;
   logic                  out_en;

   psi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   psi_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_data      (req_data),
      .out_valid    (fr_valid),
      .out_ready    (fr_ready),
      .out_radicand (fr_radicand),
      .out_side     (fr_side)
   );

   psi_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fr_valid),
      .in_ready    (fr_ready),
      .in_radicand (fr_radicand),
      .in_side     (fr_side),
      .out_valid   (sq_valid),
      .out_ready   (sq_ready),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   psi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   assign out_en   = !rsp_valid_ff || rsp_ready;
   assign dv_ready = out_en;

   always_comb begin
      logic [psi_pkg::VEC_W-1:0] res[3];
      logic signed [23:0]        sv;
      for (int i = 0; i < 3; i++) begin
         sv = dv_side.neg[i] ? -$signed(24'(dv_quo[i])) : $signed(24'(dv_quo[i]));
         res[i] = dv_side.lamb ? psi_pkg::sat_vec(sv) : dv_side.alt[i];
      end
      rsp_in.new_dir_x = res[0];
      rsp_in.new_dir_y = res[1];
      rsp_in.new_dir_z = res[2];
      rsp_in.outcome   = dv_side.outcome;
      rsp_in.process   = dv_side.process;
      rsp_in.retry     = dv_side.retry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_retry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.retry |->
         rsp_ff.new_dir_x == '0 && rsp_ff.new_dir_y == '0 && rsp_ff.new_dir_z == '0)
      else $error("retry result carries a non-zero direction");

   a_absorb_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.process == psi_pkg::PROC_ABSORPTION |->
         rsp_ff.outcome == psi_pkg::OUT_ABSORBED)
      else $error("absorption process with a non-absorbed outcome");

   a_retry_lambert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.retry |->
         (rsp_ff.outcome == psi_pkg::OUT_BACK && rsp_ff.process == psi_pkg::PROC_LAMBERT) ||
         (rsp_ff.outcome == psi_pkg::OUT_FORWARD &&
          rsp_ff.process == psi_pkg::PROC_TRANSMISSION))
      else $error("retry raised outside Lambertian scattering");

   a_lamb_unit: assert property (@(posedge clock) disable iff (reset)
      dv_valid && dv_side.lamb |-> !dv_side.retry)
      else $error("normalised result flagged for retry");

endmodule

@@ dv/photon_fate_check.sv @@
`timescale 1ns / 1ps
module photon_fate_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  psi_pkg::psi_req_type  req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  psi_pkg::psi_rsp_type  rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [psi_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic                  csr_pready,
   output int                    pending,
   output int                    mismatches
);

   localparam logic [psi_pkg::CSR_ADDR_W-1:0] ADDR_LOSS     = 4'd0;
   localparam logic [psi_pkg::CSR_ADDR_W-1:0] ADDR_SPECULAR = 4'd4;
   localparam logic [psi_pkg::CSR_ADDR_W-1:0] ADDR_SCATTER  = 4'd8;
   localparam logic [psi_pkg::CSR_ADDR_W-1:0] ADDR_MODE     = 4'd12;

   psi_pkg::psi_cfg_type cfg;
   psi_pkg::psi_rsp_type fate_queue[$];
   int beat_count;

   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] clamp_dir(input longint v);
      longint one;
      one = longint'(1) << psi_pkg::VEC_FRAC_BITS;
      if (v > one) v = one;
      if (v < -one) v = -one;
      return v[15:0];
   endfunction

   function automatic psi_pkg::psi_rsp_type predict_fate(input psi_pkg::psi_req_type q,
                                                         input psi_pkg::psi_cfg_type c);
      longint k[3], n[3], r[3], res[3], v[3];
      longint d, mag;
      logic [63:0] lim1, lim2, lim3, norm2, s, num, quo, rnd;
      logic [1:0] outc, proc;
      logic rty;
      psi_pkg::psi_rsp_type o;
      k = '{longint'(q.dir_x), longint'(q.dir_y), longint'(q.dir_z)};
      n = '{longint'(q.normal_x), longint'(q.normal_y), longint'(q.normal_z)};
      r = '{longint'(q.random_dir_x), longint'(q.random_dir_y), longint'(q.random_dir_z)};
      res = k;
      outc = psi_pkg::OUT_NONE;
      proc = psi_pkg::PROC_TRANSMISSION;
      rty = 1'b0;
      rnd = q.random_fraction;
      lim1 = c.loss_probability;
      lim2 = lim1 + c.specular_probability;
      lim3 = lim2 + c.scatter_probability;
      if (rnd < lim1) begin
         outc = psi_pkg::OUT_ABSORBED;
         proc = psi_pkg::PROC_ABSORPTION;
      end else if (rnd < lim2) begin
         d = k[0] * n[0] + k[1] * n[1] + k[2] * n[2];
         for (int i = 0; i < 3; i++) begin
            mag = 2 * d * n[i];
            mag = mag < 0 ? -mag : mag;
            mag = (mag + (longint'(1) << (2 * psi_pkg::VEC_FRAC_BITS - 1)))
                  >>> (2 * psi_pkg::VEC_FRAC_BITS);
            res[i] = k[i] - ((2 * d * n[i]) < 0 ? -mag : mag);
         end
         outc = psi_pkg::OUT_BACK;
         proc = psi_pkg::PROC_SPECULAR;
      end else if (rnd < lim3 && c.scatter_mode == psi_pkg::MODE_ISO) begin
         d = r[0] * n[0] + r[1] * n[1] + r[2] * n[2];
         res = r;
         if (d < 0) begin
            outc = psi_pkg::OUT_BACK;
            proc = psi_pkg::PROC_LAMBERT;
         end else begin
            outc = psi_pkg::OUT_FORWARD;
            proc = psi_pkg::PROC_TRANSMISSION;
         end
      end else if (rnd < lim3 && (c.scatter_mode == psi_pkg::MODE_BACK ||
                                  c.scatter_mode == psi_pkg::MODE_FWD)) begin
         norm2 = 0;
         for (int i = 0; i < 3; i++) begin
            v[i] = (c.scatter_mode == psi_pkg::MODE_FWD) ? r[i] + n[i] : r[i] - n[i];
            norm2 += v[i] * v[i];
         end
         if (c.scatter_mode == psi_pkg::MODE_FWD) begin
            outc = psi_pkg::OUT_FORWARD;
            proc = psi_pkg::PROC_TRANSMISSION;
         end else begin
            outc = psi_pkg::OUT_BACK;
            proc = psi_pkg::PROC_LAMBERT;
         end
         if (norm2 * 64'd1000000 < (64'd1 << (2 * psi_pkg::VEC_FRAC_BITS))) begin
            rty = 1'b1;
            res = '{0, 0, 0};
         end else begin
            s = root_floor(norm2 << (2 * psi_pkg::NORM_GUARD));
            for (int i = 0; i < 3; i++) begin
               num = (v[i] < 0 ? -v[i] : v[i]);
               num = num << (psi_pkg::VEC_FRAC_BITS + psi_pkg::NORM_GUARD);
               quo = (2 * num + s) / (2 * s);
               if (quo > (64'd1 << psi_pkg::VEC_FRAC_BITS))
                  quo = 64'd1 << psi_pkg::VEC_FRAC_BITS;
               res[i] = v[i] < 0 ? -longint'(quo) : longint'(quo);
            end
         end
      end
      o.new_dir_x = clamp_dir(res[0]);
      o.new_dir_y = clamp_dir(res[1]);
      o.new_dir_z = clamp_dir(res[2]);
      o.outcome = outc;
      o.process = proc;
      o.retry = rty;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("beat %0d: %s is %0h, expected %0h", beat_count, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      psi_pkg::psi_rsp_type want;
      if (reset) begin
         cfg <= '0;
         fate_queue.delete();
         mismatches <= 0;
         beat_count <= 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               ADDR_LOSS:     cfg.loss_probability <= csr_pwdata[15:0];
               ADDR_SPECULAR: cfg.specular_probability <= csr_pwdata[15:0];
               ADDR_SCATTER:  cfg.scatter_probability <= csr_pwdata[15:0];
               ADDR_MODE:     cfg.scatter_mode <= csr_pwdata[1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) fate_queue.push_back(predict_fate(req_data, cfg));
         if (rsp_valid && rsp_ready) begin
            beat_count <= beat_count + 1;
            if (fate_queue.size() == 0) begin
               report_mismatch("results outstanding", 0, 1);
            end else begin
               want = fate_queue.pop_front();
               if (rsp_data.new_dir_x !== want.new_dir_x)
                  report_mismatch("new_dir_x", rsp_data.new_dir_x, want.new_dir_x);
               if (rsp_data.new_dir_y !== want.new_dir_y)
                  report_mismatch("new_dir_y", rsp_data.new_dir_y, want.new_dir_y);
               if (rsp_data.new_dir_z !== want.new_dir_z)
                  report_mismatch("new_dir_z", rsp_data.new_dir_z, want.new_dir_z);
               if (rsp_data.outcome !== want.outcome)
                  report_mismatch("outcome", rsp_data.outcome, want.outcome);
               if (rsp_data.process !== want.process)
                  report_mismatch("process", rsp_data.process, want.process);
               if (rsp_data.retry !== want.retry)
                  report_mismatch("retry", rsp_data.retry, want.retry);
            end
         end
         pending <= fate_queue.size();
      end
   end
endmodule

@@ dv/tb_photon_surface_interaction.sv @@
`timescale 1ns / 1ps
module tb_photon_surface_interaction;

   localparam logic [psi_pkg::CSR_ADDR_W-1:0] ADDR_LOSS     = 4'd0;
   localparam logic [psi_pkg::CSR_ADDR_W-1:0] ADDR_SPECULAR = 4'd4;
   localparam logic [psi_pkg::CSR_ADDR_W-1:0] ADDR_SCATTER  = 4'd8;
   localparam logic [psi_pkg::CSR_ADDR_W-1:0] ADDR_MODE     = 4'd12;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   psi_pkg::psi_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   psi_pkg::psi_rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [psi_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int pending, mismatches;
   int send_idle_pct, recv_stall_pct;

   photon_surface_interaction uut (.*);

   photon_fate_check checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("photon_surface_interaction test failed");
      $finish;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic write_reg(input logic [psi_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // The block must hold no beats before its registers change.
   task automatic set_surface(input int loss, input int spec, input int scat,
                              input logic [1:0] mode);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      write_reg(ADDR_LOSS, loss);
      write_reg(ADDR_SPECULAR, spec);
      write_reg(ADDR_SCATTER, scat);
      write_reg(ADDR_MODE, {30'd0, mode});
      @(posedge clock);
   endtask

   function automatic logic [15:0] vec_comp();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 16'sd16384;
      if (pick == 1) return -16'sd16384;
      if (pick == 2) return 16'd0;
      return 16'($urandom_range(32768) - 16384);
   endfunction

   // Kinds: 0 random, 1 axis extremes, 2 random dir equal to normal,
   // 3 random dir opposite to normal, 4 random dir just off the normal in x and y, with z of the opposite sign.
   function automatic psi_pkg::psi_req_type make_photon(input int kind);
      psi_pkg::psi_req_type p;
      p.random_fraction = 16'($urandom);
      p.dir_x = vec_comp();
      p.dir_y = vec_comp();
      p.dir_z = vec_comp();
      p.normal_x = vec_comp();
      p.normal_y = vec_comp();
      p.normal_z = vec_comp();
      p.random_dir_x = vec_comp();
      p.random_dir_y = vec_comp();
      p.random_dir_z = vec_comp();
      case (kind)
         1: begin
            p.dir_x = -16'sd16384; p.dir_y = 0; p.dir_z = 0;
            p.normal_x = 16'sd16384; p.normal_y = 0; p.normal_z = 0;
            p.random_dir_x = 0; p.random_dir_y = 0; p.random_dir_z = 16'sd16384;
         end
         2: begin
            p.random_dir_x = p.normal_x; p.random_dir_y = p.normal_y;
            p.random_dir_z = p.normal_z;
         end
         3: begin
            p.random_dir_x = -p.normal_x; p.random_dir_y = -p.normal_y;
            p.random_dir_z = -p.normal_z;
         end
         4: begin
            p.random_dir_x = p.normal_x + 16'($urandom_range(2));
            p.random_dir_y = p.normal_y - 16'($urandom_range(1));
            p.random_dir_z = -p.normal_z;
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic send_photon(input psi_pkg::psi_req_type p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic run_phase(input int count, input int idle_kind);
      int kind;
      case (idle_kind)
         0: begin send_idle_pct = 0; recv_stall_pct = 0; end
         1: begin send_idle_pct = 70; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 70; end
         default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         send_photon(make_photon(kind < 5 ? 0 : kind - 5));
         if (i == count / 2 && idle_kind == 3) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short directed pass: every special vector under each kind of window.
      for (int k = 0; k < 5; k++) send_photon(make_photon(k));
      req_valid <= 1'b0;
      set_surface(16384, 16384, 32767, psi_pkg::MODE_BACK);
      for (int k = 0; k < 5; k++) send_photon(make_photon(k));
      req_valid <= 1'b0;
      set_surface(0, 16384, 49151, psi_pkg::MODE_FWD);
      for (int k = 0; k < 5; k++) send_photon(make_photon(k));
      req_valid <= 1'b0;
      set_surface(0, 0, 65535, psi_pkg::MODE_ISO);
      for (int k = 0; k < 5; k++) send_photon(make_photon(k));
      req_valid <= 1'b0;

      set_surface(65535, 0, 0, psi_pkg::MODE_ISO);          run_phase(120, 0);
      set_surface(0, 65535, 0, psi_pkg::MODE_ISO);          run_phase(150, 1);
      set_surface(0, 0, 65535, psi_pkg::MODE_BACK);         run_phase(170, 2);
      set_surface(0, 0, 65535, psi_pkg::MODE_FWD);          run_phase(170, 3);
      set_surface(0, 0, 65535, psi_pkg::MODE_ISO);          run_phase(150, 0);
      set_surface(0, 0, 65535, MODE_UNUSED);                run_phase(100, 1);
      set_surface(20000, 20000, 20000, psi_pkg::MODE_BACK); run_phase(200, 2);
      set_surface(40000, 40000, 40000, psi_pkg::MODE_FWD);  run_phase(200, 3);
      set_surface(65535, 65535, 65535, MODE_UNUSED);        run_phase(100, 0);
      set_surface(10000, 15000, 30000, psi_pkg::MODE_ISO);  run_phase(200, 1);
      set_surface(0, 30000, 35535, psi_pkg::MODE_BACK);     run_phase(270, 3);

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("photon_surface_interaction test passed");
      end else begin
         $display("photon_surface_interaction test failed");
      end
      $finish;
   end
endmodule
